/* rtl/tam_pkg.sv */
// ---------------------------------------------------------------------------
// tam_pkg
// shared constants, types and helpers of the transpose address map
// ---------------------------------------------------------------------------
package tam_pkg;

  localparam int unsigned MAX_RANK  = 4;
  localparam int unsigned SIZE_BITS = 16;
  localparam int unsigned MAP_BITS  = 2;
  localparam int unsigned IDX_W     = 32;
  localparam int unsigned RANK_W    = 3;
  localparam int unsigned CFG_W     = 64;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CNT_W     = 34;
  localparam int unsigned PROD_W    = CNT_W + SIZE_BITS;
  localparam int unsigned NCELL     = MAX_RANK * IDX_W;

  localparam logic [CNT_W-1:0] COUNT_CAP = 34'h2_0000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_RANK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_RANK  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_SIZES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_SIZES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_MAP     = 3'd4;

  typedef struct packed {
    logic [IDX_W-1:0]                         idx;
    logic [IDX_W-1:0]                         quo;
    logic [SIZE_BITS:0]                       part;
    logic [MAX_RANK-1:0][SIZE_BITS-1:0]       coord;
  } tam_item_t;

  function automatic logic [CNT_W-1:0] cap_count(input logic [PROD_W-1:0] p);
    logic [CNT_W-1:0] r;
    if (p > PROD_W'(COUNT_CAP)) begin
      r = COUNT_CAP;
    end else begin
      r = p[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/tam_cell.sv */
// ---------------------------------------------------------------------------
// tam_cell
// one restoring division step of the coordinate split chain
// ---------------------------------------------------------------------------
module tam_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic [tam_pkg::MAP_BITS-1:0]  axis_i,
  input  logic                          last_i,
  input  logic [tam_pkg::SIZE_BITS-1:0] divisor_i,
  input  logic                          valid_i,
  input  tam_pkg::tam_item_t            item_i,
  output logic                          valid_o,
  output tam_pkg::tam_item_t            item_o
);

  logic [tam_pkg::SIZE_BITS:0] r2;
  logic [tam_pkg::SIZE_BITS:0] dext;
  logic [tam_pkg::SIZE_BITS:0] pn;
  logic                        ge;
  tam_pkg::tam_item_t          item_d;
  tam_pkg::tam_item_t          item_q;
  logic                        valid_q;

  assign r2   = {item_i.part[tam_pkg::SIZE_BITS-1:0], item_i.quo[tam_pkg::IDX_W-1]};
  assign dext = {1'b0, divisor_i};
  assign ge   = (r2 >= dext);
  assign pn   = ge ? (r2 - dext) : r2;

  always_comb begin
    item_d      = item_i;
    item_d.quo  = {item_i.quo[tam_pkg::IDX_W-2:0], ge};
    item_d.part = pn;
    // remainder of the last step is this axis coordinate
    if (last_i) begin
      item_d.coord[axis_i] = pn[tam_pkg::SIZE_BITS-1:0];
      item_d.part          = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* rtl/nd_transpose_address_map_core.sv */
// ---------------------------------------------------------------------------
// nd_transpose_address_map_core
// generalised transpose address generator, output index to source index
// ---------------------------------------------------------------------------
// takes one output index per cycle and returns one source index per cycle
// while the output is not stalled; a chain of 128 division cells (32 per
// output axis) splits the index into coordinates, then one multiply stage
// and two add stages recombine them with the source strides. the whole chain
// advances together whenever the output register is empty or being taken.
module nd_transpose_address_map_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tam_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tam_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tam_pkg::IDX_W-1:0]      output_index_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [tam_pkg::IDX_W-1:0]      source_index_o,
  output logic                           out_of_range_o
);

  localparam int unsigned SB = tam_pkg::SIZE_BITS;
  localparam int unsigned MR = tam_pkg::MAX_RANK;

  logic [tam_pkg::RANK_W-1:0] src_rank_q, out_rank_q;
  logic [tam_pkg::CFG_W-1:0]  src_sizes_q, out_sizes_q;
  logic [7:0]                 axis_map_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rank_q  <= 3'd1;
      out_rank_q  <= 3'd1;
      src_sizes_q <= 64'h0001_0001_0001_0001;
      out_sizes_q <= 64'h0001_0001_0001_0001;
      axis_map_q  <= 8'hE4;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tam_pkg::REG_SOURCE_RANK:  src_rank_q  <= cfg_data_i[tam_pkg::RANK_W-1:0];
        tam_pkg::REG_OUTPUT_RANK:  out_rank_q  <= cfg_data_i[tam_pkg::RANK_W-1:0];
        tam_pkg::REG_SOURCE_SIZES: src_sizes_q <= cfg_data_i;
        tam_pkg::REG_OUTPUT_SIZES: out_sizes_q <= cfg_data_i;
        tam_pkg::REG_AXIS_MAP:     axis_map_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // effective ranks
  logic [tam_pkg::RANK_W-1:0] rs, ro;
  always_comb begin
    rs = src_rank_q;
    ro = out_rank_q;
    if (rs == '0) rs = 3'd1;
    if (rs > tam_pkg::RANK_W'(MR)) rs = tam_pkg::RANK_W'(MR);
    if (ro == '0) ro = 3'd1;
    if (ro > tam_pkg::RANK_W'(MR)) ro = tam_pkg::RANK_W'(MR);
  end

  logic [MR-1:0][SB-1:0] osz, ssz, odiv, ocnt;
  always_comb begin
    for (int k = 0; k < MR; k++) begin
      osz[k]  = out_sizes_q[k*SB +: SB];
      ssz[k]  = src_sizes_q[k*SB +: SB];
      odiv[k] = ((tam_pkg::RANK_W'(k) < ro) && (osz[k] != '0)) ? osz[k] : SB'(1);
      ocnt[k] = (tam_pkg::RANK_W'(k) < ro) ? osz[k] : SB'(1);
    end
  end

  // element count and source strides, settled long before any item reaches them
  logic [2*SB-1:0]         cnt01_q, st2_q;
  logic [tam_pkg::CNT_W-1:0] cnt2_q, count_q, st3_q;
  always_ff @(posedge clk_i) begin
    cnt01_q <= (2*SB)'(ocnt[0]) * (2*SB)'(ocnt[1]);
    cnt2_q  <= tam_pkg::cap_count(tam_pkg::PROD_W'(cnt01_q) * tam_pkg::PROD_W'(ocnt[2]));
    count_q <= tam_pkg::cap_count(tam_pkg::PROD_W'(cnt2_q) * tam_pkg::PROD_W'(ocnt[3]));
    st2_q   <= (2*SB)'(ssz[0]) * (2*SB)'(ssz[1]);
    st3_q   <= tam_pkg::cap_count(tam_pkg::PROD_W'(st2_q) * tam_pkg::PROD_W'(ssz[2]));
  end

  logic [MR-1:0][tam_pkg::CNT_W-1:0] stride;
  assign stride[0] = tam_pkg::CNT_W'(1);
  assign stride[1] = tam_pkg::CNT_W'(ssz[0]);
  assign stride[2] = tam_pkg::CNT_W'(st2_q);
  assign stride[3] = st3_q;

  logic adv;
  logic vc_q;
  assign adv        = !vc_q || out_ready_i;
  assign in_ready_o = adv;

  // division chain
  logic                 chain_v    [tam_pkg::NCELL+1];
  tam_pkg::tam_item_t   chain_item [tam_pkg::NCELL+1];

  assign chain_v[0]    = in_valid_i;
  assign chain_item[0] = '{idx: output_index_i, quo: output_index_i, part: '0, coord: '0};

  for (genvar i = 0; i < tam_pkg::NCELL; i++) begin : g_cell
    localparam logic [tam_pkg::MAP_BITS-1:0] Axis = tam_pkg::MAP_BITS'(i / tam_pkg::IDX_W);
    localparam logic Last = ((i % tam_pkg::IDX_W) == (tam_pkg::IDX_W - 1));
    tam_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .en_i      (adv),
      .axis_i    (Axis),
      .last_i    (Last),
      .divisor_i (odiv[Axis]),
      .valid_i   (chain_v[i]),
      .item_i    (chain_item[i]),
      .valid_o   (chain_v[i+1]),
      .item_o    (chain_item[i+1])
    );
  end

  // stage a: coordinate selection and stride products
  tam_pkg::tam_item_t                 e;
  logic [MR-1:0][SB-1:0]              csel;
  logic [MR-1:0][tam_pkg::PROD_W-1:0] prod_d;
  logic [tam_pkg::MAP_BITS-1:0]       m;
  assign e = chain_item[tam_pkg::NCELL];

  always_comb begin
    for (int j = 0; j < MR; j++) begin
      m = axis_map_q[j*tam_pkg::MAP_BITS +: tam_pkg::MAP_BITS];
      csel[j] = ({1'b0, m} < ro) ? e.coord[m] : '0;
      prod_d[j] = (tam_pkg::RANK_W'(j) < rs) ?
                  tam_pkg::PROD_W'(csel[j]) * tam_pkg::PROD_W'(stride[j]) : '0;
    end
  end

  logic                               va_q, vb_q;
  logic [MR-1:0][tam_pkg::PROD_W-1:0] prod_q;
  logic                               oora_q, oorb_q;
  logic [tam_pkg::PROD_W:0]           s01_q, s23_q;
  logic [tam_pkg::PROD_W+1:0]         sum;
  logic [tam_pkg::IDX_W-1:0]          src_q;
  logic                               oorc_q;

  assign sum = {1'b0, s01_q} + {1'b0, s23_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= chain_v[tam_pkg::NCELL];
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
      oora_q <= (tam_pkg::CNT_W'(e.idx) >= count_q);
      s01_q  <= {1'b0, prod_q[0]} + {1'b0, prod_q[1]};
      s23_q  <= {1'b0, prod_q[2]} + {1'b0, prod_q[3]};
      oorb_q <= oora_q;
      // flag an out-of-range index or an overflow of the 32-bit source index
      if (oorb_q || (sum[tam_pkg::PROD_W+1:tam_pkg::IDX_W] != '0)) begin
        oorc_q <= 1'b1;
        src_q  <= '0;
      end else begin
        oorc_q <= 1'b0;
        src_q  <= sum[tam_pkg::IDX_W-1:0];
      end
    end
  end

  assign out_valid_o    = vc_q;
  assign source_index_o = src_q;
  assign out_of_range_o = oorc_q;

endmodule

/* rtl/tam_checker.sv */
// ---------------------------------------------------------------------------
// tam_checker
// port-level checks of the transpose address map
// ---------------------------------------------------------------------------
module tam_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [tam_pkg::IDX_W-1:0]     source_index_o,
  input logic                          out_of_range_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(source_index_o))
    else $error("result changed while stalled");

  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_of_range_o |-> source_index_o == '0)
    else $error("flagged transaction carries a non-zero index");

  // the chain only stops when a result is waiting and not taken
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output state");

endmodule

bind nd_transpose_address_map_core tam_checker u_tam_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .source_index_o (source_index_o),
  .out_of_range_o (out_of_range_o)
);

/* test/nd_transpose_address_map_core_tb.sv */
// ---------------------------------------------------------------------------
// nd_transpose_address_map_core_tb
// self-checking bench for the transpose address generator
// ---------------------------------------------------------------------------
// drives output indices through a valid/ready channel under several register
// settings, predicts each source index and range flag, and compares every
// result transaction in order against the queue of expected addresses
module nd_transpose_address_map_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LATENCY = 131;

  typedef struct packed {
    logic [tam_pkg::IDX_W-1:0] src;
    logic                      oor;
  } addr_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [tam_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [tam_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  logic [tam_pkg::IDX_W-1:0]     output_index_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  logic [tam_pkg::IDX_W-1:0]     source_index_o;
  logic                          out_of_range_o;

  // model copy of the registers
  logic [tam_pkg::RANK_W-1:0] m_src_rank;
  logic [tam_pkg::RANK_W-1:0] m_out_rank;
  logic [tam_pkg::CFG_W-1:0]  m_src_sizes;
  logic [tam_pkg::CFG_W-1:0]  m_out_sizes;
  logic [7:0]                 m_axis_map;

  logic [tam_pkg::IDX_W-1:0] pending_idx[$];
  addr_t                     expected_addr[$];
  int                        errors = 0;
  int                        hold_off = 0;
  int                        in_gap = 0;
  int                        out_gap = 0;

  nd_transpose_address_map_core u_top (.*);

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_rank(logic [tam_pkg::RANK_W-1:0] r);
    if (r == 0) return 1;
    if (r > tam_pkg::MAX_RANK) return tam_pkg::MAX_RANK;
    return r;
  endfunction

  function automatic logic [63:0] cap64(logic [63:0] p);
    return (p > 64'(tam_pkg::COUNT_CAP)) ? 64'(tam_pkg::COUNT_CAP) : p;
  endfunction

  function automatic addr_t transpose_addr(logic [tam_pkg::IDX_W-1:0] idx);
    int unsigned rs, ro, m;
    logic [63:0] cnt, rem, s, stride, sum;
    logic [63:0] coord[tam_pkg::MAX_RANK];
    addr_t r;
    rs = clamp_rank(m_src_rank);
    ro = clamp_rank(m_out_rank);
    cnt = 1;
    for (int k = 0; k < ro; k++)
      cnt = cap64(cnt * 64'(m_out_sizes[k*tam_pkg::SIZE_BITS +: tam_pkg::SIZE_BITS]));
    r = '{src: '0, oor: 1'b1};
    if (64'(idx) >= cnt) return r;
    rem = 64'(idx);
    for (int k = 0; k < tam_pkg::MAX_RANK; k++) begin
      s = 64'(m_out_sizes[k*tam_pkg::SIZE_BITS +: tam_pkg::SIZE_BITS]);
      if (k < ro && s != 0) begin
        coord[k] = rem % s;
        rem = rem / s;
      end else begin
        coord[k] = 0;
      end
    end
    stride = 1;
    sum = 0;
    for (int k = 0; k < rs; k++) begin
      m = m_axis_map[k*2 +: 2];
      sum += ((m < ro) ? coord[m] : 64'd0) * stride;
      stride = cap64(stride * 64'(m_src_sizes[k*tam_pkg::SIZE_BITS +: tam_pkg::SIZE_BITS]));
    end
    if (sum <= 64'hFFFF_FFFF) r = '{src: sum[tam_pkg::IDX_W-1:0], oor: 1'b0};
    return r;
  endfunction

  function automatic int unsigned rand_gap();
    if ($urandom_range(9) < 6) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      expected_addr.push_back(transpose_addr(output_index_i));
    end
    if (!in_valid_i || in_ready_o) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_valid_i <= 1'b0;
      end else if (pending_idx.size() > 0) begin
        output_index_i <= pending_idx.pop_front();
        in_valid_i <= 1'b1;
        in_gap <= rand_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    addr_t exp_a;
    if (out_valid_o && out_ready_i) begin
      if (expected_addr.size() == 0) begin
        $display("%0t: unexpected result source_index=%h out_of_range=%b", $time,
                 source_index_o, out_of_range_o);
        errors++;
      end else begin
        exp_a = expected_addr.pop_front();
        if (exp_a.src !== source_index_o) begin
          $display("%0t: source_index expected %h actual %h", $time, exp_a.src,
                   source_index_o);
          errors++;
        end
        if (exp_a.oor !== out_of_range_o) begin
          $display("%0t: out_of_range expected %b actual %b", $time, exp_a.oor,
                   out_of_range_o);
          errors++;
        end
      end
    end
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready_i <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap <= out_gap - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      out_gap <= rand_gap();
    end
  end

  task automatic write_reg(logic [tam_pkg::CFG_IDX_W-1:0] index,
                           logic [tam_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i <= data;
    case (index)
      tam_pkg::REG_SOURCE_RANK:  m_src_rank <= data[tam_pkg::RANK_W-1:0];
      tam_pkg::REG_OUTPUT_RANK:  m_out_rank <= data[tam_pkg::RANK_W-1:0];
      tam_pkg::REG_SOURCE_SIZES: m_src_sizes <= data;
      tam_pkg::REG_OUTPUT_SIZES: m_out_sizes <= data;
      tam_pkg::REG_AXIS_MAP:     m_axis_map <= data[7:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_idx.size() > 0 || in_valid_i || expected_addr.size() > 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  function automatic logic [63:0] rand_sizes(int unsigned maxs, bit zeros);
    logic [63:0] v;
    for (int k = 0; k < tam_pkg::MAX_RANK; k++) begin
      v[k*16 +: 16] = (zeros && $urandom_range(7) == 0) ? 16'd0 : 16'($urandom_range(maxs, 1));
    end
    return v;
  endfunction

  // indices mostly inside the output count, some beyond it
  task automatic queue_random(int n);
    logic [63:0] cnt;
    cnt = 1;
    for (int k = 0; k < clamp_rank(m_out_rank); k++)
      cnt = cap64(cnt * 64'(m_out_sizes[k*16 +: 16]));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8 && cnt > 0 && cnt <= 64'hFFFF_FFFF)
        pending_idx.push_back(tam_pkg::IDX_W'($urandom_range(32'(cnt - 1), 0)));
      else if ($urandom_range(1)) pending_idx.push_back($urandom);
      else pending_idx.push_back(tam_pkg::IDX_W'(cnt) + tam_pkg::IDX_W'($urandom_range(3)));
    end
  endtask

  initial begin
    m_src_rank = 1;
    m_out_rank = 1;
    m_src_sizes = 64'h0001_0001_0001_0001;
    m_out_sizes = 64'h0001_0001_0001_0001;
    m_axis_map = 8'hE4;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset setting: only index zero is in range
    pending_idx.push_back(32'd0);
    pending_idx.push_back(32'd1);
    pending_idx.push_back(32'hFFFF_FFFF);
    drain();

    // largest sizes, rank 4 each way, reversed map: source overflow and full index range
    write_reg(tam_pkg::REG_SOURCE_RANK, 64'd4);
    write_reg(tam_pkg::REG_OUTPUT_RANK, 64'd4);
    write_reg(tam_pkg::REG_SOURCE_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tam_pkg::REG_OUTPUT_SIZES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(tam_pkg::REG_AXIS_MAP, 64'h1B);
    pending_idx.push_back(32'd0);
    pending_idx.push_back(32'hFFFF_FFFF);
    pending_idx.push_back(32'h8000_0000);
    pending_idx.push_back(32'h5555_5555);
    pending_idx.push_back(32'hAAAA_AAAA);
    pending_idx.push_back(32'd65535);
    pending_idx.push_back(32'd65536);
    drain();

    // rank 0 and 7 clamp, every axis mapped to output axis 3, zero source size, map past output rank
    write_reg(tam_pkg::REG_SOURCE_RANK, 64'd7);
    write_reg(tam_pkg::REG_OUTPUT_RANK, 64'd0);
    write_reg(tam_pkg::REG_SOURCE_SIZES, 64'h0003_0000_0005_0002);
    write_reg(tam_pkg::REG_OUTPUT_SIZES, 64'h0002_0003_0004_0007);
    write_reg(tam_pkg::REG_AXIS_MAP, 64'hFF);
    for (int i = 0; i < 8; i++) pending_idx.push_back(tam_pkg::IDX_W'(i));
    drain();

    // zero output size makes everything out of range
    write_reg(tam_pkg::REG_OUTPUT_RANK, 64'd3);
    write_reg(tam_pkg::REG_OUTPUT_SIZES, 64'h0001_0000_0003_0004);
    pending_idx.push_back(32'd0);
    pending_idx.push_back(32'd5);
    drain();

    // long receiver stall so the pipeline fills and back-pressures
    write_reg(tam_pkg::REG_OUTPUT_RANK, 64'd2);
    write_reg(tam_pkg::REG_OUTPUT_SIZES, 64'h0001_0001_0100_0100);
    write_reg(tam_pkg::REG_SOURCE_RANK, 64'd2);
    write_reg(tam_pkg::REG_SOURCE_SIZES, 64'h0001_0001_0100_0100);
    write_reg(tam_pkg::REG_AXIS_MAP, 64'hE1);
    @(posedge clk_i);
    hold_off <= 400;
    queue_random(300);
    drain();

    // random settings
    for (int ph = 0; ph < 16; ph++) begin
      write_reg(tam_pkg::REG_SOURCE_RANK, 64'($urandom_range(7)));
      write_reg(tam_pkg::REG_OUTPUT_RANK, 64'($urandom_range(7)));
      if (ph % 4 == 3) begin
        write_reg(tam_pkg::REG_SOURCE_SIZES, {$urandom, $urandom});
        write_reg(tam_pkg::REG_OUTPUT_SIZES, {$urandom, $urandom});
      end else begin
        write_reg(tam_pkg::REG_SOURCE_SIZES, rand_sizes(ph % 2 ? 300 : 12, 1'b1));
        write_reg(tam_pkg::REG_OUTPUT_SIZES, rand_sizes(ph % 2 ? 300 : 12, ph % 4 == 2));
      end
      write_reg(tam_pkg::REG_AXIS_MAP, 64'($urandom_range(255)));
      queue_random(100);
      drain();
    end

    if (errors == 0 && expected_addr.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
